>>> sv/psd_pkg.sv
// ============================================================================
// Point-segment distance package
// Shared widths, codes and payload types for the squared distance unit.
// ============================================================================
package psd_pkg;

    // Coordinate format is fixed by the payload: signed Q12.4
    localparam int COORD_WIDTH     = 16;
    localparam int T_FRAC_BITS_DEF = 16;

    // Derived datapath widths
    localparam int DIFF_W = COORD_WIDTH + 1;      // P-A, B-A, P-B
    localparam int PROD_W = 2 * DIFF_W;           // one product of two differences
    localparam int LEN_W  = 2 * DIFF_W;           // sum of two squares of differences
    localparam int DOT_W  = 2 * DIFF_W + 1;       // signed dot product
    localparam int REM_W  = LEN_W + 1;            // divider partial remainder
    localparam int RES_W  = DIFF_W + 1;           // residual to projected point
    localparam int SUM_W  = 2 * RES_W;            // sum of two residual squares
    localparam int SEL_W  = (SUM_W > LEN_W) ? SUM_W : LEN_W;
    localparam int DIST_W = 33;

    // Configuration port
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_IDX_W   = CFG_ADDR_W - 2;
    localparam int LIMIT_W     = 16;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET          = LIMIT_W'(26);
    localparam logic [CFG_IDX_W-1:0] REG_DEGENERATE_LIMIT = '0;

    typedef enum logic [1:0] {
        CASE_BEFORE   = 2'd0,
        CASE_BEYOND   = 2'd1,
        CASE_INTERIOR = 2'd2,
        CASE_DEGEN    = 2'd3
    } nearest_case_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] px;
        logic signed [COORD_WIDTH-1:0] py;
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic signed [COORD_WIDTH-1:0] bx;
        logic signed [COORD_WIDTH-1:0] by;
    } psd_query_t;

    typedef struct packed {
        logic [DIST_W-1:0] dist_sq;
        logic [1:0]        nearest_case;
    } psd_result_t;

    // Context that rides alongside the divider
    typedef struct packed {
        nearest_case_t            ncase;
        logic                     div_needed;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] ex;
        logic signed [DIFF_W-1:0] ey;
        logic [LEN_W-1:0]         dist_a;
        logic [LEN_W-1:0]         dist_b;
    } psd_ctx_t;

endpackage

>>> sv/psd_cfg.sv
// ============================================================================
// Point-segment distance configuration registers
// APB-style register file holding the degenerate segment limit.
// ============================================================================
module psd_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [psd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [psd_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [psd_pkg::LIMIT_W-1:0]     limit
);
    import psd_pkg::*;

    logic [LIMIT_W-1:0]   limit_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_DEGENERATE_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_DEGENERATE_LIMIT)
        begin
            prdata = {{(CFG_DATA_W-LIMIT_W){1'b0}}, limit_reg};
        end
    end

    assign pready = 1'b1;
    assign limit  = limit_reg;

endmodule

>>> sv/psd_front.sv
// ============================================================================
// Point-segment distance front end
// Four stages: differences, products, sums, case classification.
// ============================================================================
module psd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid_in,
    input  psd_pkg::psd_query_t           query,
    input  logic [psd_pkg::LIMIT_W-1:0]   limit,
    output logic                          valid_out,
    output psd_pkg::psd_ctx_t             ctx,
    output logic [psd_pkg::REM_W-1:0]     rem,
    output logic [psd_pkg::LEN_W-1:0]     len2
);
    import psd_pkg::*;

    // stage 1: differences
    logic                     s1_valid_reg;
    logic signed [DIFF_W-1:0] s1_dx_reg, s1_dy_reg, s1_ex_reg, s1_ey_reg, s1_fx_reg, s1_fy_reg;
    // stage 2: products
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] s2_ex2_reg, s2_ey2_reg, s2_dxex_reg, s2_dyey_reg;
    logic signed [PROD_W-1:0] s2_dx2_reg, s2_dy2_reg, s2_fx2_reg, s2_fy2_reg;
    logic signed [DIFF_W-1:0] s2_dx_reg, s2_dy_reg, s2_ex_reg, s2_ey_reg;
    // stage 3: sums
    logic                     s3_valid_reg;
    logic [LEN_W-1:0]         s3_len2_reg, s3_dist_a_reg, s3_dist_b_reg;
    logic signed [DOT_W-1:0]  s3_dot_reg;
    logic signed [DIFF_W-1:0] s3_dx_reg, s3_dy_reg, s3_ex_reg, s3_ey_reg;
    // stage 4: classification
    logic                     s4_valid_reg;
    psd_ctx_t                 s4_ctx_reg, s4_ctx_next;
    logic [REM_W-1:0]         s4_rem_reg, s4_rem_next;
    logic [LEN_W-1:0]         s4_len2_reg;

    logic degen, dot_neg, far_past;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= valid_in;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dx_reg <= DIFF_W'(query.px) - DIFF_W'(query.ax);
        s1_dy_reg <= DIFF_W'(query.py) - DIFF_W'(query.ay);
        s1_ex_reg <= DIFF_W'(query.bx) - DIFF_W'(query.ax);
        s1_ey_reg <= DIFF_W'(query.by) - DIFF_W'(query.ay);
        s1_fx_reg <= DIFF_W'(query.px) - DIFF_W'(query.bx);
        s1_fy_reg <= DIFF_W'(query.py) - DIFF_W'(query.by);

        s2_ex2_reg  <= s1_ex_reg * s1_ex_reg;
        s2_ey2_reg  <= s1_ey_reg * s1_ey_reg;
        s2_dxex_reg <= s1_dx_reg * s1_ex_reg;
        s2_dyey_reg <= s1_dy_reg * s1_ey_reg;
        s2_dx2_reg  <= s1_dx_reg * s1_dx_reg;
        s2_dy2_reg  <= s1_dy_reg * s1_dy_reg;
        s2_fx2_reg  <= s1_fx_reg * s1_fx_reg;
        s2_fy2_reg  <= s1_fy_reg * s1_fy_reg;
        s2_dx_reg   <= s1_dx_reg;
        s2_dy_reg   <= s1_dy_reg;
        s2_ex_reg   <= s1_ex_reg;
        s2_ey_reg   <= s1_ey_reg;

        s3_len2_reg   <= LEN_W'($unsigned(s2_ex2_reg)) + LEN_W'($unsigned(s2_ey2_reg));
        s3_dist_a_reg <= LEN_W'($unsigned(s2_dx2_reg)) + LEN_W'($unsigned(s2_dy2_reg));
        s3_dist_b_reg <= LEN_W'($unsigned(s2_fx2_reg)) + LEN_W'($unsigned(s2_fy2_reg));
        s3_dot_reg    <= DOT_W'(s2_dxex_reg) + DOT_W'(s2_dyey_reg);
        s3_dx_reg     <= s2_dx_reg;
        s3_dy_reg     <= s2_dy_reg;
        s3_ex_reg     <= s2_ex_reg;
        s3_ey_reg     <= s2_ey_reg;

        s4_ctx_reg  <= s4_ctx_next;
        s4_rem_reg  <= s4_rem_next;
        s4_len2_reg <= s3_len2_reg;
    end

    // Settle every case that needs no quotient; only a projection between
    // zero and two segment lengths goes through the divider.
    always_comb
    begin
        degen    = (s3_len2_reg == '0) || (s3_len2_reg < LEN_W'(limit));
        dot_neg  = s3_dot_reg[DOT_W-1];
        far_past = $unsigned(s3_dot_reg) >= {s3_len2_reg, 1'b0};

        s4_ctx_next.dx         = s3_dx_reg;
        s4_ctx_next.dy         = s3_dy_reg;
        s4_ctx_next.ex         = s3_ex_reg;
        s4_ctx_next.ey         = s3_ey_reg;
        s4_ctx_next.dist_a     = s3_dist_a_reg;
        s4_ctx_next.dist_b     = s3_dist_b_reg;
        s4_ctx_next.div_needed = 1'b0;
        if (degen)
        begin
            s4_ctx_next.ncase = CASE_DEGEN;
        end
        else if (dot_neg)
        begin
            s4_ctx_next.ncase = CASE_BEFORE;
        end
        else if (far_past)
        begin
            s4_ctx_next.ncase = CASE_BEYOND;
        end
        else
        begin
            s4_ctx_next.ncase      = CASE_INTERIOR;
            s4_ctx_next.div_needed = 1'b1;
        end
        s4_rem_next = s4_ctx_next.div_needed ? REM_W'($unsigned(s3_dot_reg)) : '0;
    end

    assign valid_out = s4_valid_reg;
    assign ctx       = s4_ctx_reg;
    assign rem       = s4_rem_reg;
    assign len2      = s4_len2_reg;

endmodule

>>> sv/psd_div.sv
// ============================================================================
// Point-segment distance divider
// Pipelined restoring divider, one quotient bit per stage.
// ============================================================================
module psd_div #(
    parameter int T_FRAC_BITS = psd_pkg::T_FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid_in,
    input  psd_pkg::psd_ctx_t           ctx_in,
    input  logic [psd_pkg::REM_W-1:0]   rem_in,
    input  logic [psd_pkg::LEN_W-1:0]   len2_in,
    output logic                        valid_out,
    output psd_pkg::psd_ctx_t           ctx_out,
    output logic [T_FRAC_BITS:0]        t_out
);
    import psd_pkg::*;

    localparam int T_W   = T_FRAC_BITS + 1;
    localparam int NSTEP = T_FRAC_BITS + 1;

    logic             valid_reg [NSTEP];
    psd_ctx_t         ctx_reg   [NSTEP];
    logic [REM_W-1:0] rem_reg   [NSTEP];
    logic [LEN_W-1:0] len_reg   [NSTEP];
    logic [T_W-1:0]   q_reg     [NSTEP];

    for (genvar k = 0; k < NSTEP; k++)
    begin : g_step
        logic             v_src;
        psd_ctx_t         ctx_src;
        logic [LEN_W-1:0] len_src;
        logic [T_W-1:0]   q_src;
        logic [REM_W-1:0] shifted;
        logic [REM_W:0]   trial;
        logic             q_bit;

        // First stage takes the integer bit: the dividend is already below
        // twice the divisor, so no shift is needed there.
        if (k == 0)
        begin : g_first
            assign v_src   = valid_in;
            assign ctx_src = ctx_in;
            assign len_src = len2_in;
            assign q_src   = '0;
            assign shifted = rem_in;
        end
        else
        begin : g_next
            assign v_src   = valid_reg[k-1];
            assign ctx_src = ctx_reg[k-1];
            assign len_src = len_reg[k-1];
            assign q_src   = q_reg[k-1];
            assign shifted = {rem_reg[k-1][REM_W-2:0], 1'b0};
        end

        assign trial = {1'b0, shifted} - {2'b00, len_src};
        assign q_bit = !trial[REM_W];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            ctx_reg[k] <= ctx_src;
            len_reg[k] <= len_src;
            rem_reg[k] <= q_bit ? trial[REM_W-1:0] : shifted;
            q_reg[k]   <= {q_src[T_W-2:0], q_bit};
        end
    end

    assign valid_out = valid_reg[NSTEP-1];
    assign ctx_out   = ctx_reg[NSTEP-1];
    assign t_out     = q_reg[NSTEP-1];

endmodule

>>> sv/psd_back.sv
// ============================================================================
// Point-segment distance back end
// Projection offset, residual squares, case select and saturation.
// ============================================================================
module psd_back #(
    parameter int T_FRAC_BITS = psd_pkg::T_FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid_in,
    input  psd_pkg::psd_ctx_t     ctx_in,
    input  logic [T_FRAC_BITS:0]  t_in,
    output logic                  done,
    output psd_pkg::psd_result_t  result
);
    import psd_pkg::*;

    localparam int T_W   = T_FRAC_BITS + 1;
    localparam int PJ_W  = T_W + 1 + DIFF_W;
    localparam int CMP_W = (SEL_W > DIST_W + 1) ? SEL_W : DIST_W + 1;
    localparam logic signed [PJ_W-1:0] HALF    = PJ_W'(1) <<< (T_FRAC_BITS - 1);
    localparam logic [CMP_W-1:0]       SAT_MAX = {{(CMP_W-DIST_W){1'b0}}, {DIST_W{1'b1}}};

    // P1: projection products and final case
    logic                     p1_valid_reg;
    nearest_case_t            p1_case_reg, p1_case_next;
    logic signed [PJ_W-1:0]   p1_px_reg, p1_py_reg;
    logic signed [DIFF_W-1:0] p1_dx_reg, p1_dy_reg;
    logic [LEN_W-1:0]         p1_dist_a_reg, p1_dist_b_reg;
    // P2: residuals
    logic                     p2_valid_reg;
    nearest_case_t            p2_case_reg;
    logic signed [RES_W-1:0]  p2_rx_reg, p2_ry_reg;
    logic [LEN_W-1:0]         p2_dist_a_reg, p2_dist_b_reg;
    // P3: residual squares
    logic                     p3_valid_reg;
    nearest_case_t            p3_case_reg;
    logic signed [SUM_W-1:0]  p3_sqx_reg, p3_sqy_reg;
    logic [LEN_W-1:0]         p3_dist_a_reg, p3_dist_b_reg;
    // P4: output
    logic                     done_reg;
    psd_result_t              result_reg, result_next;

    logic signed [T_W:0]      t_s;
    logic signed [PJ_W-1:0]   rnd_x, rnd_y;
    logic signed [RES_W-1:0]  qx, qy;
    logic [SUM_W-1:0]         interior_sum;
    logic [SEL_W-1:0]         sel_dist;
    logic [CMP_W-1:0]         wide_dist;

    assign t_s = {1'b0, t_in};

    // Quotient above one means the point lies beyond the end
    always_comb
    begin
        p1_case_next = ctx_in.ncase;
        if (ctx_in.div_needed && t_in[T_W-1] && (t_in[T_W-2:0] != '0))
        begin
            p1_case_next = CASE_BEYOND;
        end
    end

    // Round half up: add half an LSB, then floor by arithmetic shift
    assign rnd_x = p1_px_reg + HALF;
    assign rnd_y = p1_py_reg + HALF;
    assign qx    = $signed(rnd_x[T_FRAC_BITS +: RES_W]);
    assign qy    = $signed(rnd_y[T_FRAC_BITS +: RES_W]);

    always_comb
    begin
        interior_sum = $unsigned(p3_sqx_reg) + $unsigned(p3_sqy_reg);
        case (p3_case_reg)
            CASE_INTERIOR: sel_dist = SEL_W'(interior_sum);
            CASE_BEYOND:   sel_dist = SEL_W'(p3_dist_b_reg);
            default:       sel_dist = SEL_W'(p3_dist_a_reg);
        endcase
        wide_dist = CMP_W'(sel_dist);
        result_next.dist_sq      = (wide_dist > SAT_MAX) ? {DIST_W{1'b1}}
                                                         : wide_dist[DIST_W-1:0];
        result_next.nearest_case = p3_case_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= valid_in;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            done_reg     <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_case_reg   <= p1_case_next;
        p1_px_reg     <= t_s * ctx_in.ex;
        p1_py_reg     <= t_s * ctx_in.ey;
        p1_dx_reg     <= ctx_in.dx;
        p1_dy_reg     <= ctx_in.dy;
        p1_dist_a_reg <= ctx_in.dist_a;
        p1_dist_b_reg <= ctx_in.dist_b;

        p2_case_reg   <= p1_case_reg;
        p2_rx_reg     <= RES_W'(p1_dx_reg) - qx;
        p2_ry_reg     <= RES_W'(p1_dy_reg) - qy;
        p2_dist_a_reg <= p1_dist_a_reg;
        p2_dist_b_reg <= p1_dist_b_reg;

        p3_case_reg   <= p2_case_reg;
        p3_sqx_reg    <= p2_rx_reg * p2_rx_reg;
        p3_sqy_reg    <= p2_ry_reg * p2_ry_reg;
        p3_dist_a_reg <= p2_dist_a_reg;
        p3_dist_b_reg <= p2_dist_b_reg;

        result_reg    <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> sv/point_segment_distance_squared_unit.sv
// ============================================================================
// Point to segment squared distance unit
// Fully pipelined squared distance from a 2D point to a line segment.
// ============================================================================
// Raise start with a query (point P, segment A to B, signed Q12.4) and the
// transaction is taken on that edge; busy stays low, so a new query may be
// issued on every clock cycle. Each result appears on result for exactly one
// cycle with done high, in query order. The receiver cannot hold results off,
// so sample result whenever done is high. The depth is set by the projection
// divider, which resolves one quotient bit per stage, T_FRAC_BITS + 1 stages
// in all, between a four-stage front end (differences, products, sums,
// classification) and a four-stage back end (projection offset, residual,
// square, select and saturate).
// dist_sq is in 1/256 units, saturated at 2^33-1. nearest_case gives where
// the nearest point lies: before the start, beyond the end, on the interior,
// or a segment whose squared length is zero or below degenerate_limit (distance to the start).
// Register map: degenerate_limit at byte address 0, 16 bits, reset 26.
// Write it only while no transaction is in flight.
// ============================================================================
module point_segment_distance_squared_unit #(
    parameter int T_FRAC_BITS = psd_pkg::T_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [psd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [psd_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    // query side
    input  logic                            start,
    output logic                            busy,
    input  psd_pkg::psd_query_t             query,
    // result side
    output logic                            done,
    output psd_pkg::psd_result_t            result
);
    import psd_pkg::*;

    logic [LIMIT_W-1:0] limit;
    logic               accept;

    logic               fe_valid;
    psd_ctx_t           fe_ctx;
    logic [REM_W-1:0]   fe_rem;
    logic [LEN_W-1:0]   fe_len2;

    logic               dv_valid;
    psd_ctx_t           dv_ctx;
    logic [T_FRAC_BITS:0] dv_t;

    // Every stage advances every cycle: never hold off a query
    assign busy   = 1'b0;
    assign accept = start && !busy;

    psd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limit   (limit)
    );

    // Differences, products, sums; settle every case not needing the quotient
    psd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (accept),
        .query     (query),
        .limit     (limit),
        .valid_out (fe_valid),
        .ctx       (fe_ctx),
        .rem       (fe_rem),
        .len2      (fe_len2)
    );

    // Projection parameter t = floor(dot * 2^T_FRAC_BITS / len2)
    psd_div #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (fe_valid),
        .ctx_in    (fe_ctx),
        .rem_in    (fe_rem),
        .len2_in   (fe_len2),
        .valid_out (dv_valid),
        .ctx_out   (dv_ctx),
        .t_out     (dv_t)
    );

    // Projected point, residual distance, case select and saturation
    psd_back #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (dv_valid),
        .ctx_in   (dv_ctx),
        .t_in     (dv_t),
        .done     (done),
        .result   (result)
    );

endmodule

>>> tb/psd_distance_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// Point-segment distance checker
// Watches the query, result and register channels, predicts each squared
// distance and compares every result with the oldest outstanding prediction.
// ============================================================================
module psd_distance_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [psd_pkg::CFG_DATA_W-1:0]  pwdata,
    input  logic [psd_pkg::CFG_DATA_W-1:0]  prdata,
    input  logic                            pready,
    input  logic                            start,
    input  logic                            busy,
    input  psd_pkg::psd_query_t             query,
    input  logic                            done,
    input  psd_pkg::psd_result_t            result,
    output int                              pending,
    output int                              mismatches
);
    import psd_pkg::*;

    localparam logic [LIMIT_W-1:0] LIMIT_AT_RESET = 16'd26;
    localparam int                 PROJ_FRAC      = T_FRAC_BITS_DEF;
    localparam longint             DIST_CEILING   = (longint'(1) << DIST_W) - 1;

    logic [LIMIT_W-1:0] limit_q;
    psd_result_t        distance_q[$];

    function automatic longint square_sum(input longint a, input longint b);
        longint s;
        s = a * a + b * b;
        return (s > DIST_CEILING) ? DIST_CEILING : s;
    endfunction

    // Offset of the projected point along one axis, rounded half up to Q.4
    function automatic longint proj_offset(input longint t, input longint e);
        longint v;
        v = t * e + (longint'(1) << (PROJ_FRAC - 1));
        return v >>> PROJ_FRAC;
    endfunction

    function automatic psd_result_t predict_distance(input psd_query_t q,
                                                     input logic [LIMIT_W-1:0] lim);
        longint        px, py, ax, ay, bx, by;
        longint        dx, dy, ex, ey, len2, dot, t, dist_val;
        nearest_case_t code;
        psd_result_t   r;
        px = longint'($signed(q.px));
        py = longint'($signed(q.py));
        ax = longint'($signed(q.ax));
        ay = longint'($signed(q.ay));
        bx = longint'($signed(q.bx));
        by = longint'($signed(q.by));
        dx = px - ax;
        dy = py - ay;
        ex = bx - ax;
        ey = by - ay;
        len2 = ex * ex + ey * ey;
        if (len2 == 0 || len2 < longint'({48'd0, lim}))
        begin
            dist_val = square_sum(dx, dy);
            code = CASE_DEGEN;
        end
        else
        begin
            dot = dx * ex + dy * ey;
            if (dot < 0)
            begin
                dist_val = square_sum(dx, dy);
                code = CASE_BEFORE;
            end
            else
            begin
                t = (dot <<< PROJ_FRAC) / len2;
                if (t > (longint'(1) << PROJ_FRAC))
                begin
                    dist_val = square_sum(px - bx, py - by);
                    code = CASE_BEYOND;
                end
                else
                begin
                    dist_val = square_sum(dx - proj_offset(t, ex), dy - proj_offset(t, ey));
                    code = CASE_INTERIOR;
                end
            end
        end
        r.dist_sq      = dist_val[DIST_W-1:0];
        r.nearest_case = code;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : observe
        psd_result_t want;
        int          errs;
        if (!rst_n)
        begin
            limit_q <= LIMIT_AT_RESET;
            distance_q.delete();
            pending    <= 0;
            mismatches <= 0;
        end
        else
        begin
            errs = 0;
            if (done)
            begin
                if (distance_q.size() == 0)
                begin
                    $error("result transaction with no query outstanding");
                    errs++;
                end
                else
                begin
                    want = distance_q.pop_front();
                    if (result.dist_sq !== want.dist_sq)
                    begin
                        $error("dist_sq: expected %0d, got %0d", want.dist_sq, result.dist_sq);
                        errs++;
                    end
                    if (result.nearest_case !== want.nearest_case)
                    begin
                        $error("nearest_case: expected %0d, got %0d",
                               want.nearest_case, result.nearest_case);
                        errs++;
                    end
                end
            end
            if (start && !busy)
                distance_q.push_back(predict_distance(query, limit_q));
            if (psel && penable && pready && paddr[CFG_ADDR_W-1:2] == REG_DEGENERATE_LIMIT)
            begin
                if (pwrite)
                    limit_q <= pwdata[LIMIT_W-1:0];
                else if (prdata !== {{(CFG_DATA_W-LIMIT_W){1'b0}}, limit_q})
                begin
                    $error("degenerate_limit: expected %0d, got %0d", limit_q, prdata);
                    errs++;
                end
            end
            pending    <= distance_q.size();
            mismatches <= mismatches + errs;
        end
    end

endmodule

>>> tb/point_segment_distance_squared_unit_test.sv
`timescale 1ns / 100ps
// ============================================================================
// Point to segment squared distance unit test
// Drives directed and random queries through several degenerate_limit
// settings; a checker beside the unit predicts and compares every result.
// ============================================================================
module point_segment_distance_squared_unit_test;
    import psd_pkg::*;

    // Result latency of the unit
    localparam int RESULT_LATENCY = T_FRAC_BITS_DEF + 9;
    localparam int STALL_LIMIT    = 1000;
    localparam int PHASE_COUNT    = 6;
    localparam int RANDOM_PER_PHASE = 300;

    // Register index with nothing behind it; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 1'b1;

    typedef enum int {SHAPE_WIDE, SHAPE_SHORT, SHAPE_NEAR, SHAPE_CORNER} query_shape_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  start;
    logic                  busy;
    psd_query_t            query;
    logic                  done;
    psd_result_t           result;

    int pending;
    int mismatches;
    int stall_cycles = 0;
    bit gaps_on;

    point_segment_distance_squared_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .query   (query),
        .done    (done),
        .result  (result)
    );

    psd_distance_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .query      (query),
        .done       (done),
        .result     (result),
        .pending    (pending),
        .mismatches (mismatches)
    );

    always #5 clk = ~clk;

    // Watchdog: count cycles in which no transaction of any kind completes,
    // and abandon the run if the unit goes quiet for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable && pready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic psd_query_t make_query(input int px, input int py, input int ax,
                                              input int ay, input int bx, input int by);
        psd_query_t q;
        q.px = COORD_WIDTH'(px);
        q.py = COORD_WIDTH'(py);
        q.ax = COORD_WIDTH'(ax);
        q.ay = COORD_WIDTH'(ay);
        q.bx = COORD_WIDTH'(bx);
        q.by = COORD_WIDTH'(by);
        return q;
    endfunction

    function automatic int any_coord();
        return int'($signed(COORD_WIDTH'($urandom())));
    endfunction

    // Bias towards the rails, zero and minus one
    function automatic int edge_coord();
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return any_coord();
        endcase
    endfunction

    function automatic int jitter(input int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // Build one random query; out-of-range sums simply wrap to 16 bits
    function automatic psd_query_t random_query();
        query_shape_t shape;
        int           ax, ay, bx, by, frac;
        int           pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            shape = SHAPE_WIDE;
        else if (pick < 60)
            shape = SHAPE_SHORT;
        else if (pick < 85)
            shape = SHAPE_NEAR;
        else
            shape = SHAPE_CORNER;
        case (shape)
            SHAPE_WIDE:
                return make_query(any_coord(), any_coord(), any_coord(), any_coord(),
                                  any_coord(), any_coord());
            SHAPE_SHORT:
            begin
                // short segments straddle the degenerate threshold
                ax = any_coord();
                ay = any_coord();
                return make_query(ax + jitter(200), ay + jitter(200), ax, ay,
                                  ax + jitter(20), ay + jitter(20));
            end
            SHAPE_NEAR:
            begin
                // point close to the line, projection spread around both ends
                ax = any_coord();
                ay = any_coord();
                bx = ax + jitter(8000);
                by = ay + jitter(8000);
                frac = $urandom_range(0, 1600) - 300;
                return make_query(ax + (bx - ax) * frac / 1000 + jitter(64),
                                  ay + (by - ay) * frac / 1000 + jitter(64),
                                  ax, ay, bx, by);
            end
            default:
                return make_query(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                                  edge_coord(), edge_coord());
        endcase
    endfunction

    // Mostly back to back, some short gaps, now and then a long one
    function automatic int sender_gap();
        int pick;
        if (!gaps_on)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Present one query and hold it until the unit takes the transaction
    task automatic send_query(input psd_query_t q);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        query <= q;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    // Register access: setup, then access until pready
    task automatic register_access(input logic is_write, input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_limit(input logic [CFG_DATA_W-1:0] data);
        register_access(1'b1, REG_DEGENERATE_LIMIT, data);
        register_access(1'b0, REG_DEGENERATE_LIMIT, '0);
    endtask

    initial
    begin : stimulus
        int c;
        clk          = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        start        = 1'b0;
        query        = '0;
        gaps_on      = 1'b1;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Confirm the reset value of the limit before anything is written
        register_access(1'b0, REG_DEGENERATE_LIMIT, '0);

        // Directed queries at the reset limit
        send_query(make_query(0, 0, 0, 0, 0, 0));
        send_query(make_query(32767, 32767, -32768, -32768, -32768, -32768));
        // length squared just under and just at the default limit
        send_query(make_query(10, -7, 0, 0, 3, 4));
        send_query(make_query(40, 40, 0, 0, 1, 5));
        send_query(make_query(100, 100, 100, 100, 101, 100));
        // before the start, beyond the end, interior
        send_query(make_query(-50, 30, 0, 0, 160, 0));
        send_query(make_query(300, -20, 0, 0, 160, 0));
        send_query(make_query(80, 45, 0, 0, 160, 0));
        // projection exactly at the end counts as interior; exactly at start too
        send_query(make_query(160, 77, 0, 0, 160, 0));
        send_query(make_query(0, -99, 0, 0, 160, 0));
        // full-range coordinates
        send_query(make_query(32767, -32768, -32768, -32768, 32767, 32767));
        send_query(make_query(-32768, -32768, 32767, -32768, -32768, 32767));
        send_query(make_query(-32768, 32767, -32768, 32767, 32767, -32768));
        send_query(make_query(32767, 0, -32768, 0, 0, 0));
        send_query(make_query(-32768, 1, 0, 0, 32767, 0));
        send_query(make_query(32767, 32767, 32767, 32767, -32768, -32768));
        // negative offsets exercise rounding towards plus infinity
        send_query(make_query(-5, -1, 0, 0, -7, -3));
        send_query(make_query(-3, -2, 0, 0, -7, -3));
        send_query(make_query(999, 500, 0, 0, 1000, 1));

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase > 0)
            begin
                // Retune only once every outstanding result is back
                drain_results();
                case (phase)
                    1: set_limit(32'd0);
                    2: set_limit({16'($urandom_range(0, 65535)), 16'hFFFF});
                    3:
                    begin
                        register_access(1'b1, REG_UNMAPPED, $urandom());
                        set_limit($urandom());
                    end
                    4: set_limit(32'd1);
                    default: set_limit($urandom_range(20, 2000));
                endcase
            end
            // Zero-length segment in every setting, including a limit of zero
            c = any_coord();
            send_query(make_query(any_coord(), any_coord(), c, -c, c, -c));
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // Switch gaps on and off in runs so some stretches are dense
                if (n % 50 == 0)
                    gaps_on = ($urandom_range(0, 3) != 0);
                send_query(random_query());
            end
        end

        drain_results();
        repeat (2 * RESULT_LATENCY) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
        begin
            if (pending != 0)
                $error("%0d results never arrived", pending);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/psd_pkg.sv
sv/psd_cfg.sv
sv/psd_front.sv
sv/psd_div.sv
sv/psd_back.sv
sv/point_segment_distance_squared_unit.sv
tb/psd_distance_checker.sv
tb/point_segment_distance_squared_unit_test.sv
